// ===== design/phbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phbm_pkg: shared types and constants of the peak-hold bar meter renderer
// Holds the sequencer state type, the ring control and scan status structs,
// the register map codes and the peak-row character function.
// ----------------------------------------------------------------------------
package phbm_pkg;

    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COL_W   = 5;

    // Write positions within the 42 writes of one level
    localparam logic [POS_W-1:0] POS_BAR_CMD   = 6'd0;
    localparam logic [POS_W-1:0] POS_PEAK_CMD  = 6'd21;
    localparam logic [POS_W-1:0] POS_PEAK_COL0 = 6'd22;
    localparam logic [POS_W-1:0] POS_LAST      = 6'd41;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_BAR_ROW_ADDR  = 8'h94;
    localparam logic [BYTE_W-1:0] RST_PEAK_ROW_ADDR = 8'hC0;
    localparam logic [BYTE_W-1:0] RST_BAR_GLYPH     = 8'hFF;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_BAR_ROW_ADDR  = 2'd0,
        REG_PEAK_ROW_ADDR = 2'd1,
        REG_BAR_GLYPH     = 2'd2,
        REG_NONE          = 2'd3
    } phbm_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } phbm_state_t;

    typedef struct packed {
        logic               load;
        logic [LEVEL_W-1:0] level;
    } phbm_ring_ctl_t;

    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] peak;
    } phbm_scan_stat_t;

    // Character of the peak row at column col for a given peak
    function automatic logic [BYTE_W-1:0] phbm_peak_char(
        input logic [LEVEL_W-1:0] peak,
        input logic [COL_W-1:0]   col
    );
        logic [COL_W-1:0]  p;
        logic [BYTE_W-1:0] ch;
        p  = {1'b0, peak};
        ch = CHAR_SPACE;
        if (peak == '0) begin
            ch = CHAR_SPACE;
        end else if (peak <= 4'd9) begin
            if (col == p - 5'd1) begin
                ch = CHAR_ZERO + {4'b0, peak};
            end
        end else begin
            if (col == p - 5'd1) begin
                ch = CHAR_PLUS;
            end else if (col == p) begin
                ch = CHAR_ZERO + {4'b0, peak} - 8'd9;
            end else if (col == p + 5'd1) begin
                ch = CHAR_ZERO;
            end
        end
        return ch;
    endfunction

endpackage

// ===== design/phbm_ring_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phbm_ring_scan: level history ring with a serial peak scan
// Stores each level in a WINDOW-entry ring, then walks the ring one entry
// per cycle through a single compare unit to find the window maximum.
// ----------------------------------------------------------------------------
module phbm_ring_scan #(
    parameter int unsigned WINDOW = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  phbm_pkg::phbm_ring_ctl_t ctl,
    output phbm_pkg::phbm_scan_stat_t stat
);
    import phbm_pkg::*;

    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

    logic [LEVEL_W-1:0] ring_reg [WINDOW];
    logic [IDX_W-1:0]   wr_ptr_reg,   wr_ptr_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               busy_reg,     busy_next;
    logic [LEVEL_W-1:0] peak_reg,     peak_next;
    logic [LEVEL_W-1:0] entry;

    assign entry = ring_reg[scan_idx_reg];

    always_comb begin
        wr_ptr_next   = wr_ptr_reg;
        scan_idx_next = scan_idx_reg;
        busy_next     = busy_reg;
        peak_next     = peak_reg;
        if (ctl.load) begin
            wr_ptr_next   = (wr_ptr_reg == IDX_LAST) ? '0 : wr_ptr_reg + 1'b1;
            scan_idx_next = '0;
            busy_next     = 1'b1;
            peak_next     = '0;
        end else if (busy_reg) begin
            // one compare per cycle
            if (entry > peak_reg) begin
                peak_next = entry;
            end
            scan_idx_next = scan_idx_reg + 1'b1;
            if (scan_idx_reg == IDX_LAST) begin
                busy_next     = 1'b0;
                scan_idx_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            wr_ptr_reg   <= '0;
            scan_idx_reg <= '0;
            busy_reg     <= 1'b0;
            peak_reg     <= '0;
        end else begin
            if (ctl.load) begin
                ring_reg[wr_ptr_reg] <= ctl.level;
            end
            wr_ptr_reg   <= wr_ptr_next;
            scan_idx_reg <= scan_idx_next;
            busy_reg     <= busy_next;
            peak_reg     <= peak_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.peak = peak_reg;

`ifndef ASSERT_OFF
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg <= IDX_LAST) && (scan_idx_reg <= IDX_LAST))
        else $error("ring pointer out of range");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !ctl.load && (scan_idx_reg == IDX_LAST) |=> !busy_reg)
        else $error("peak scan did not finish after last entry");

    a_peak_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !ctl.load |=> $stable(peak_reg))
        else $error("peak changed while scan idle");
`endif

endmodule

// ===== design/peak_hold_bar_meter_render.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_hold_bar_meter_render: peak-hold bar graph meter for a text display
// Turns each signal level into the 42 display writes of a bar row and a
// peak marker row.
// ----------------------------------------------------------------------------
// Each accepted level produces 42 write transfers on the m_ side: the bar row
// command byte, 20 bar characters, the peak row command byte and 20 peak
// characters, the last one flagged by m_tlast. The block accepts a level in
// its idle state; then the output sequencer issues one write per cycle while
// m_tready stays high, and downstream stalls hold it. s_tready is high only
// between items. The peak over the last WINDOW levels is found by a serial
// scan, one ring entry per cycle, that runs while the bar row goes out, so it
// is ready before the peak row starts.
// The history ring clears at reset. Registers are written through the APB
// port at any time the block is idle.
// ----------------------------------------------------------------------------
module peak_hold_bar_meter_render #(
    parameter int unsigned WINDOW = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] level, [7:4] zero
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] write_byte
    output logic        m_tuser,   // [0] is_command
    output logic        m_tlast,   // last_write
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import phbm_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] bar_addr_reg;
    logic [BYTE_W-1:0] peak_addr_reg;
    logic [BYTE_W-1:0] glyph_reg;
    logic              cfg_wr;
    phbm_reg_t         reg_sel;

    // Sequencer
    phbm_state_t       state_reg, state_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [LEVEL_W-1:0] level_reg;
    logic              in_xfer;
    logic              emit;

    // Output register
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_cmd_reg;
    logic              m_last_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              cmd_next;

    // Ring / scan
    phbm_ring_ctl_t    ring_ctl;
    phbm_scan_stat_t   scan_stat;

    logic [POS_W-1:0]  bar_col;
    logic [POS_W-1:0]  peak_col;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = phbm_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_addr_reg  <= RST_BAR_ROW_ADDR;
            peak_addr_reg <= RST_PEAK_ROW_ADDR;
            glyph_reg     <= RST_BAR_GLYPH;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_BAR_ROW_ADDR:  bar_addr_reg  <= pwdata[BYTE_W-1:0];
                REG_PEAK_ROW_ADDR: peak_addr_reg <= pwdata[BYTE_W-1:0];
                REG_BAR_GLYPH:     glyph_reg     <= pwdata[BYTE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_BAR_ROW_ADDR:  prdata = {24'b0, bar_addr_reg};
            REG_PEAK_ROW_ADDR: prdata = {24'b0, peak_addr_reg};
            REG_BAR_GLYPH:     prdata = {24'b0, glyph_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- ring and peak scan ----------------
    assign ring_ctl.load  = in_xfer;
    assign ring_ctl.level = s_tdata[LEVEL_W-1:0];

    phbm_ring_scan #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ring_ctl),
        .stat    (scan_stat)
    );

    // ---------------- sequencer ----------------
    assign in_xfer = s_tvalid && s_tready;

    // Load a new write whenever the output register is empty or being drained
    assign emit = (state_reg == ST_RUN) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer) state_next = ST_RUN;
            ST_RUN:  if (emit && (pos_reg == POS_LAST)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        pos_next = pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                pos_next = POS_BAR_CMD;
            end
            ST_RUN: begin
                if (emit) pos_next = pos_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Column numbers of the two character runs
    assign bar_col  = pos_reg - 6'd1;
    assign peak_col = pos_reg - POS_PEAK_COL0;

    // Byte of the write at the current position
    always_comb begin
        cmd_next  = 1'b0;
        byte_next = CHAR_SPACE;
        if (pos_reg == POS_BAR_CMD) begin
            cmd_next  = 1'b1;
            byte_next = bar_addr_reg;
        end else if (pos_reg < POS_PEAK_CMD) begin
            byte_next = (bar_col < {2'b0, level_reg}) ? glyph_reg : CHAR_SPACE;
        end else if (pos_reg == POS_PEAK_CMD) begin
            cmd_next  = 1'b1;
            byte_next = peak_addr_reg;
        end else begin
            byte_next = phbm_peak_char(scan_stat.peak, peak_col[COL_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= POS_BAR_CMD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the level and the pending write
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            level_reg <= s_tdata[LEVEL_W-1:0];
        end
        if (emit) begin
            m_byte_reg <= byte_next;
            m_cmd_reg  <= cmd_next;
            m_last_reg <= (pos_reg == POS_LAST);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_cmd_reg;
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_peak_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && (pos_reg >= POS_PEAK_COL0) |-> !scan_stat.busy)
        else $error("peak row started before peak scan finished");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == ST_RUN) && (pos_reg == POS_BAR_CMD))
        else $error("item transfer did not start a write run");

    a_cmd_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && cmd_next |-> (pos_reg == POS_BAR_CMD) || (pos_reg == POS_PEAK_CMD))
        else $error("command write at a character position");
`endif

endmodule

// ===== tb/phbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phbm_checker: scoreboard for the peak-hold bar meter renderer
// Watches the level stream, the display write stream and the register port,
// predicts the 42 display writes of every accepted level and compares them
// in order with the writes that come out.
// ----------------------------------------------------------------------------
module phbm_checker #(
    parameter int unsigned WINDOW = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] level, [7:4] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] write_byte
    input  logic        m_tuser,   // [0] is_command
    input  logic        m_tlast,   // last_write
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          writes_due
);
    import phbm_pkg::*;

    localparam int unsigned ROW_COLS = 20;

    typedef struct packed {
        logic       is_cmd;
        logic [7:0] wr_byte;
        logic       last;
    } display_write_t;

    display_write_t    display_writes_due[$];
    logic [3:0]        level_ring [WINDOW];
    int unsigned       ring_slot;
    logic [7:0]        bar_row_addr;
    logic [7:0]        peak_row_addr;
    logic [7:0]        bar_glyph;

    initial begin
        fail_count = 0;
        writes_due = 0;
    end

    // Peak row character at one column
    function automatic logic [7:0] peak_row_char(int unsigned pk, int unsigned col);
        if (pk == 0) begin
            return CHAR_SPACE;
        end
        if (pk < 10) begin
            return (col == pk - 1) ? CHAR_ZERO + 8'(pk) : CHAR_SPACE;
        end
        if (col == pk - 1) begin
            return CHAR_PLUS;
        end
        if (col == pk) begin
            return CHAR_ZERO + 8'(pk - 9);
        end
        if (col == pk + 1) begin
            return CHAR_ZERO;
        end
        return CHAR_SPACE;
    endfunction

    task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
        $display("[%0t] ERROR %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_val,
                 got_val);
        fail_count++;
    endtask

    // Store the level, rescan the window and queue the 42 writes it causes
    task automatic render_level(logic [3:0] lvl);
        int unsigned    pk;
        display_write_t wr;
        level_ring[ring_slot] = lvl;
        ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
        pk = 0;
        for (int unsigned i = 0; i < WINDOW; i++) begin
            if (level_ring[i] > pk) begin
                pk = level_ring[i];
            end
        end
        wr = '{is_cmd: 1'b1, wr_byte: bar_row_addr, last: 1'b0};
        display_writes_due.push_back(wr);
        for (int unsigned c = 0; c < ROW_COLS; c++) begin
            wr = '{is_cmd: 1'b0, wr_byte: (c < lvl) ? bar_glyph : CHAR_SPACE, last: 1'b0};
            display_writes_due.push_back(wr);
        end
        wr = '{is_cmd: 1'b1, wr_byte: peak_row_addr, last: 1'b0};
        display_writes_due.push_back(wr);
        for (int unsigned c = 0; c < ROW_COLS; c++) begin
            wr = '{is_cmd: 1'b0, wr_byte: peak_row_char(pk, c), last: (c == ROW_COLS - 1)};
            display_writes_due.push_back(wr);
        end
    endtask

    always @(posedge aclk) begin
        display_write_t exp_wr;
        if (!aresetn) begin
            display_writes_due.delete();
            for (int unsigned i = 0; i < WINDOW; i++) begin
                level_ring[i] = '0;
            end
            ring_slot     = 0;
            bar_row_addr  = RST_BAR_ROW_ADDR;
            peak_row_addr = RST_PEAK_ROW_ADDR;
            bar_glyph     = RST_BAR_GLYPH;
        end else begin
            // results first, so a level accepted on the same edge cannot be hit
            if (m_tvalid === 1'b1 && m_tready) begin
                if (display_writes_due.size() == 0) begin
                    report_mismatch("write transfer with none pending", 0, m_tdata);
                end else begin
                    exp_wr = display_writes_due.pop_front();
                    if (m_tuser !== exp_wr.is_cmd) begin
                        report_mismatch("is_command", exp_wr.is_cmd, m_tuser);
                    end
                    if (m_tdata !== exp_wr.wr_byte) begin
                        report_mismatch("write_byte", exp_wr.wr_byte, m_tdata);
                    end
                    if (m_tlast !== exp_wr.last) begin
                        report_mismatch("last_write", exp_wr.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready === 1'b1) begin
                render_level(s_tdata[3:0]);
            end
            if (psel && penable && pready === 1'b1) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_BAR_ROW_ADDR:  bar_row_addr  = pwdata[7:0];
                        REG_PEAK_ROW_ADDR: peak_row_addr = pwdata[7:0];
                        REG_BAR_GLYPH:     bar_glyph     = pwdata[7:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        REG_BAR_ROW_ADDR:
                            if (prdata[7:0] !== bar_row_addr) begin
                                report_mismatch("bar_row_address read", bar_row_addr,
                                                prdata[7:0]);
                            end
                        REG_PEAK_ROW_ADDR:
                            if (prdata[7:0] !== peak_row_addr) begin
                                report_mismatch("peak_row_address read", peak_row_addr,
                                                prdata[7:0]);
                            end
                        REG_BAR_GLYPH:
                            if (prdata[7:0] !== bar_glyph) begin
                                report_mismatch("bar_glyph read", bar_glyph, prdata[7:0]);
                            end
                        default: ;
                    endcase
                end
            end
        end
        writes_due = display_writes_due.size();
    end

endmodule

// ===== tb/peak_hold_bar_meter_render_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_hold_bar_meter_render_tb: stimulus and verdict for the bar meter
// Sweeps every level and peak, then streams shaped random levels through
// several register settings with random gaps on both streams; a separate
// checker predicts and compares every display write.
// ----------------------------------------------------------------------------
module peak_hold_bar_meter_render_tb;
    import phbm_pkg::*;

    localparam int unsigned WINDOW       = 10;
    localparam int unsigned MAX_GAP      = 12;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_LEVELS = 42;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [3:0] level, [7:4] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] write_byte
    logic        m_tuser;   // [0] is_command
    logic        m_tlast;   // last_write
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int writes_due;

    // When set, neither side inserts idle cycles
    bit calm;

    peak_hold_bar_meter_render #(
        .WINDOW(WINDOW)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    phbm_checker #(
        .WINDOW(WINDOW)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fail_count(fail_count),
        .writes_due(writes_due)
    );

    // 4 ns clock, first rising edge at 2 ns
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // One register transfer: setup at this falling edge, access at the next.
    // Return at the falling edge after the access edge with psel still high;
    // the caller either starts another transfer or drops psel there.
    task automatic reg_transfer(bit is_write, phbm_reg_t idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom()), val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
    endtask

    // Write the three display registers, then read each one back
    task automatic program_meter(logic [7:0] bar_addr, logic [7:0] peak_addr,
                                 logic [7:0] glyph);
        reg_transfer(1'b1, REG_BAR_ROW_ADDR, bar_addr);
        reg_transfer(1'b1, REG_PEAK_ROW_ADDR, peak_addr);
        reg_transfer(1'b1, REG_BAR_GLYPH, glyph);
        reg_transfer(1'b0, REG_BAR_ROW_ADDR, '0);
        reg_transfer(1'b0, REG_PEAK_ROW_ADDR, '0);
        reg_transfer(1'b0, REG_BAR_GLYPH, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one level after a random gap and hold it until the transfer.
    // Entered and left at a falling edge; valid stays high on a zero gap.
    task automatic send_level(logic [3:0] lvl);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, lvl};
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every queued display write has arrived
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        wait (writes_due == 0);
        @(negedge aclk);
    endtask

    // Display write receiver: draw a stall per transfer, then accept one
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [3:0]  lvl;
        logic [3:0]  cap;
        int unsigned phase;
        int unsigned n;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;

        // hold reset, then release it at a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sweep with the reset settings: rising levels walk the peak
        // through every value (single digit and the '+' marker with its
        // two-digit form), then zeros keep the old maximum inside the window.
        for (n = 0; n < 16; n++) begin
            send_level(n[3:0]);
        end
        for (n = 0; n < 9; n++) begin
            send_level(4'd0);
        end

        // Random phases, each with its own register setting. The block must
        // be idle for a register write, so drain every phase first; this also
        // makes the sender wait for all pending results.
        cap = 4'd15;
        for (phase = 0; phase < PHASES; phase++) begin
            drain_writes();
            case (phase)
                0: program_meter(8'h00, 8'h00, 8'h00);
                1: program_meter(8'hFF, 8'hFF, 8'hFF);
                2: begin
                    // write past the register list: must leave all three alone
                    reg_transfer(1'b1, REG_NONE, 8'($urandom_range(0, 255)));
                    program_meter(8'h5A, 8'hA5, 8'h2A);
                end
                default: program_meter(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
            endcase
            calm = (phase % 3 == 2);
            for (n = 0; n < PHASE_LEVELS; n++) begin
                // move the ceiling now and then, so low peaks return after
                // the window forgets the high levels
                if ($urandom_range(0, 7) == 0) begin
                    cap = 4'($urandom_range(0, 15));
                end
                if ($urandom_range(0, 15) == 0) begin
                    lvl = 4'($urandom_range(0, 15));
                end else begin
                    lvl = 4'($urandom_range(0, cap));
                end
                if ($urandom_range(0, 31) == 0) begin
                    calm = !calm;
                end
                send_level(lvl);
            end
        end

        // Let the last writes drain, then idle before the verdict
        drain_writes();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && writes_due == 0) begin
            $display("peak_hold_bar_meter_render: match");
        end else begin
            $display("peak_hold_bar_meter_render: mismatch");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("peak_hold_bar_meter_render: mismatch");
        $finish;
    end

endmodule

// ===== peak_hold_bar_meter_render.f =====
design/phbm_pkg.sv
design/phbm_ring_scan.sv
design/peak_hold_bar_meter_render.sv
tb/phbm_checker.sv
tb/peak_hold_bar_meter_render_tb.sv
